### rtl/ppmas_pkg.sv
// Shared types and constants for the pressure packet masked area summer.
// Used by every module of the block; depends on nothing.
package ppmas_pkg;

	localparam int POINTS = 28;
	localparam int MASK_W = 28;
	localparam int SUM_W = 21;
	localparam int IDX_W = 5;
	localparam int AREAS = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

	localparam logic [7:0] HDR_B0 = 8'h3C;
	localparam logic [7:0] HDR_B1 = 8'hAA;
	localparam logic [7:0] HDR_B2 = 8'h55;
	localparam logic [7:0] AREA_FIRST = 8'h41;
	localparam logic [7:0] AREA_LAST = 8'h44;

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_HDR2 = 3'd1;
	localparam logic [2:0] PH_HDR3 = 3'd2;
	localparam logic [2:0] PH_AREA = 3'd3;
	localparam logic [2:0] PH_SEQ = 3'd4;
	localparam logic [2:0] PH_LOW = 3'd5;
	localparam logic [2:0] PH_HIGH = 3'd6;

	localparam logic [CFG_IDX_W-1:0] REG_TOE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOREFOOT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIDFOOT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEEL = 3'd3;

	localparam logic [MASK_W-1:0] TOE_RST = 28'h0FFFDFBE;
	localparam logic [MASK_W-1:0] FOREFOOT_RST = 28'h0FFFFFFF;
	localparam logic [MASK_W-1:0] MIDFOOT_RST = 28'h0FFFFFFF;
	localparam logic [MASK_W-1:0] HEEL_RST = 28'h000FBFFE;

	typedef logic [AREAS-1:0][MASK_W-1:0] mask_arr_t;

	typedef struct packed {
		logic [1:0] area_index;
		logic [SUM_W-1:0] area_total;
	} res_t;

endpackage

### rtl/pressure_packet_masked_area_summer.sv
// Top level of the pressure packet masked area summer.
// Depends on ppmas_pkg, ppmas_cfg, ppmas_parse and ppmas_outq.
//
// Input channel: one received sensor byte per item on rx_byte, taken at a
// clock edge with in_valid high and in_stall low. The block scans for the
// header 3C AA 55, reads an area code 41..44, skips a sequence byte and then
// 28 little-endian 16-bit samples. Samples whose bit is set in that area's
// mask register are summed. A packet with an unknown area code is consumed
// but yields nothing.
// Output channel: area_index and area_total, taken at an edge with out_valid
// high and out_stall low. A result shows on out_valid in the cycle after the
// byte carrying the last sample's high byte is accepted.
// Throughput: one byte per cycle while in_stall is low; results pass through a
// two-entry queue; in_stall rises only while both entries hold results the receiver has not
// taken, so a stalled receiver holds the input only after two packets.
// Configuration: cfg_we writes cfg_data into mask register cfg_index
// (0 toe, 1 forefoot, 2 midfoot, 3 heel); other indexes are ignored.
// Reset: arst_n clears the parser to header hunt, empties the queue and
// loads the default masks.
module pressure_packet_masked_area_summer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] area_index,
	output logic [ppmas_pkg::SUM_W-1:0] area_total,
	input logic cfg_we,
	input logic [ppmas_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ppmas_pkg::MASK_W-1:0] cfg_data
);

	ppmas_pkg::mask_arr_t masks;
	ppmas_pkg::res_t res;
	ppmas_pkg::res_t out_data;
	logic res_valid;
	logic full;
	logic accept;

	assign in_stall = full;
	assign accept = in_valid && !full;

	ppmas_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.masks(masks)
	);

	ppmas_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.rx_byte(rx_byte),
		.masks(masks),
		.res_valid(res_valid),
		.res(res)
	);

	ppmas_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.push_data(res),
		.full(full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	assign area_index = out_data.area_index;
	assign area_total = out_data.area_total;

endmodule

### rtl/ppmas_cfg.sv
// Valid-point mask registers, one per foot area, with the write port.
// Depends on ppmas_pkg.
module ppmas_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ppmas_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ppmas_pkg::MASK_W-1:0] cfg_data,
	output ppmas_pkg::mask_arr_t masks
);

	ppmas_pkg::mask_arr_t masks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q[0] <= ppmas_pkg::TOE_RST;
			masks_q[1] <= ppmas_pkg::FOREFOOT_RST;
			masks_q[2] <= ppmas_pkg::MIDFOOT_RST;
			masks_q[3] <= ppmas_pkg::HEEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppmas_pkg::REG_TOE: masks_q[0] <= cfg_data;
				ppmas_pkg::REG_FOREFOOT: masks_q[1] <= cfg_data;
				ppmas_pkg::REG_MIDFOOT: masks_q[2] <= cfg_data;
				ppmas_pkg::REG_HEEL: masks_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign masks = masks_q;

endmodule

### rtl/ppmas_parse.sv
// Packet parser: header hunt, area decode and masked sample accumulation.
// Depends on ppmas_pkg; produces at most one result per accepted byte.
module ppmas_parse (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] rx_byte,
	input ppmas_pkg::mask_arr_t masks,
	output logic res_valid,
	output ppmas_pkg::res_t res
);

	logic [2:0] phase_q, phase_d;
	logic [1:0] area_q, area_d;
	logic known_q, known_d;
	logic [7:0] low_q, low_d;
	logic [ppmas_pkg::IDX_W-1:0] idx_q, idx_d;
	logic [ppmas_pkg::SUM_W-1:0] sum_q, sum_d;

	logic [2:0] hunt_ph;
	logic [7:0] area_off;
	logic [15:0] sample;
	logic [ppmas_pkg::MASK_W-1:0] cur_mask;
	logic bit_en;
	logic last;

	assign hunt_ph = (rx_byte == ppmas_pkg::HDR_B0) ? ppmas_pkg::PH_HDR2 : ppmas_pkg::PH_HUNT;
	assign area_off = rx_byte - ppmas_pkg::AREA_FIRST;
	assign sample = {rx_byte, low_q};
	assign cur_mask = masks[area_q];
	assign bit_en = (32'(idx_q) < ppmas_pkg::MASK_W) ? cur_mask[idx_q] : 1'b0;
	assign last = (idx_q == ppmas_pkg::LAST_IDX);

	always_comb begin
		phase_d = phase_q;
		area_d = area_q;
		known_d = known_q;
		low_d = low_q;
		idx_d = idx_q;
		sum_d = sum_q;
		res_valid = 1'b0;
		unique case (phase_q)
			ppmas_pkg::PH_HUNT: phase_d = hunt_ph;
			ppmas_pkg::PH_HDR2: begin
				phase_d = (rx_byte == ppmas_pkg::HDR_B1) ? ppmas_pkg::PH_HDR3 : hunt_ph;
			end
			ppmas_pkg::PH_HDR3: begin
				phase_d = (rx_byte == ppmas_pkg::HDR_B2) ? ppmas_pkg::PH_AREA : hunt_ph;
			end
			ppmas_pkg::PH_AREA: begin
				if (rx_byte >= ppmas_pkg::AREA_FIRST && rx_byte <= ppmas_pkg::AREA_LAST) begin
					area_d = area_off[1:0];
					known_d = 1'b1;
				end else begin
					area_d = 2'd0;
					known_d = 1'b0;
				end
				phase_d = ppmas_pkg::PH_SEQ;
			end
			ppmas_pkg::PH_SEQ: begin
				idx_d = '0;
				sum_d = '0;
				phase_d = ppmas_pkg::PH_LOW;
			end
			ppmas_pkg::PH_LOW: begin
				low_d = rx_byte;
				phase_d = ppmas_pkg::PH_HIGH;
			end
			ppmas_pkg::PH_HIGH: begin
				if (bit_en) begin
					sum_d = sum_q + ppmas_pkg::SUM_W'(sample);
				end
				if (last) begin
					res_valid = accept && known_q;
					idx_d = '0;
					phase_d = ppmas_pkg::PH_HUNT;
				end else begin
					idx_d = idx_q + 1'b1;
					phase_d = ppmas_pkg::PH_LOW;
				end
			end
			default: phase_d = ppmas_pkg::PH_HUNT;
		endcase
	end

	assign res.area_index = area_q;
	assign res.area_total = sum_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ppmas_pkg::PH_HUNT;
			area_q <= 2'd0;
			known_q <= 1'b0;
			low_q <= 8'd0;
			idx_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			area_q <= area_d;
			known_q <= known_d;
			low_q <= low_d;
			idx_q <= idx_d;
			sum_q <= sum_d;
		end
	end

endmodule

### rtl/ppmas_outq.sv
// Two-entry result queue that decouples the parser from a stalled receiver.
// Depends on ppmas_pkg.
module ppmas_outq (
	input logic clk,
	input logic arst_n,
	input logic push,
	input ppmas_pkg::res_t push_data,
	output logic full,
	output logic out_valid,
	input logic out_stall,
	output ppmas_pkg::res_t out_data
);

	ppmas_pkg::res_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic pop;

	assign out_valid = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);
	assign pop = out_valid && !out_stall;
	assign out_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/ppmas_chk.sv
// Port-level checker for the pressure packet masked area summer.
// Depends on ppmas_pkg; bound to the top level below.
module ppmas_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [1:0] area_index,
	input logic [ppmas_pkg::SUM_W-1:0] area_total
);

	localparam logic [ppmas_pkg::SUM_W-1:0] MAX_TOTAL = 21'd1834980;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(area_index) && $stable(area_total))
		else $error("stalled result changed");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input held with no result pending");

	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result appeared without an accepted item");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> area_total <= MAX_TOTAL)
		else $error("area total out of range");

endmodule

bind pressure_packet_masked_area_summer ppmas_chk u_chk (.*);

### tb/tb_pressure_packet_masked_area_summer.sv
// Self-checking testbench for pressure_packet_masked_area_summer: sends sensor byte
// streams, predicts each packet's masked area sum and checks every result in order.
// Depends on ppmas_pkg and the RTL of the block only.
module tb_pressure_packet_masked_area_summer;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 4;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_MAX, FILL_MIXED} fill_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] area_index;
	logic [ppmas_pkg::SUM_W-1:0] area_total;
	logic cfg_we = 1'b0;
	logic [ppmas_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ppmas_pkg::MASK_W-1:0] cfg_data = '0;

	int send_idle_pct = 23;
	int recv_idle_pct = 62;
	int hold_len = 0;
	int bytes_sent = 0;
	int fail_count = 0;
	int cycle_count = 0;

	logic [ppmas_pkg::MASK_W-1:0] area_masks [ppmas_pkg::AREAS];
	logic [2:0] parse_phase;
	logic [1:0] cur_area;
	logic cur_known;
	logic [7:0] low_hold;
	logic [ppmas_pkg::IDX_W-1:0] samp_idx;
	logic [ppmas_pkg::SUM_W-1:0] run_sum;
	ppmas_pkg::res_t packet_sums [$];

	pressure_packet_masked_area_summer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.area_index(area_index),
		.area_total(area_total),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic void accumulate_byte(input logic [7:0] b);
		logic [2:0] hunt;
		logic [15:0] sample;
		logic [ppmas_pkg::MASK_W-1:0] mask;
		ppmas_pkg::res_t r;
		hunt = (b == ppmas_pkg::HDR_B0) ? ppmas_pkg::PH_HDR2 : ppmas_pkg::PH_HUNT;
		case (parse_phase)
		ppmas_pkg::PH_HUNT: parse_phase = hunt;
		ppmas_pkg::PH_HDR2: parse_phase = (b == ppmas_pkg::HDR_B1) ? ppmas_pkg::PH_HDR3 : hunt;
		ppmas_pkg::PH_HDR3: parse_phase = (b == ppmas_pkg::HDR_B2) ? ppmas_pkg::PH_AREA : hunt;
		ppmas_pkg::PH_AREA: begin
			cur_known = (b >= ppmas_pkg::AREA_FIRST && b <= ppmas_pkg::AREA_LAST);
			cur_area = cur_known ? 2'(b - ppmas_pkg::AREA_FIRST) : 2'd0;
			parse_phase = ppmas_pkg::PH_SEQ;
		end
		ppmas_pkg::PH_SEQ: begin
			samp_idx = '0;
			run_sum = '0;
			parse_phase = ppmas_pkg::PH_LOW;
		end
		ppmas_pkg::PH_LOW: begin
			low_hold = b;
			parse_phase = ppmas_pkg::PH_HIGH;
		end
		default: begin
			sample = {b, low_hold};
			mask = area_masks[cur_area];
			if (samp_idx < ppmas_pkg::MASK_W && mask[samp_idx])
				run_sum = run_sum + ppmas_pkg::SUM_W'(sample);
			if (samp_idx == ppmas_pkg::LAST_IDX) begin
				if (cur_known) begin
					r.area_index = cur_area;
					r.area_total = run_sum;
					packet_sums.push_back(r);
				end
				samp_idx = '0;
				parse_phase = ppmas_pkg::PH_HUNT;
			end else begin
				samp_idx = samp_idx + 1'b1;
				parse_phase = ppmas_pkg::PH_LOW;
			end
		end
		endcase
	endfunction

	always @(posedge clk) begin : check_result
		ppmas_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (packet_sums.size() == 0) begin
				report_mismatch("result with none pending, area_total", area_total, -1);
			end else begin
				want = packet_sums.pop_front();
				if (area_index !== want.area_index)
					report_mismatch("area_index", area_index, want.area_index);
				if (area_total !== want.area_total)
					report_mismatch("area_total", area_total, want.area_total);
			end
		end
	end

	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		accumulate_byte(b);
		bytes_sent++;
	endtask

	task automatic send_header(input logic [7:0] code);
		send_byte(ppmas_pkg::HDR_B0);
		send_byte(ppmas_pkg::HDR_B1);
		send_byte(ppmas_pkg::HDR_B2);
		send_byte(code);
		send_byte(8'($urandom_range(255)));
	endtask

	task automatic send_samples(input int count, input fill_t fill);
		logic [15:0] s;
		repeat (count) begin
			case (fill)
			FILL_ZERO: s = 16'h0000;
			FILL_MAX: s = 16'hFFFF;
			FILL_MIXED: begin
				case ($urandom_range(2))
				0: s = 16'h0000;
				1: s = 16'hFFFF;
				default: s = 16'($urandom_range(65535));
				endcase
			end
			default: s = 16'($urandom_range(65535));
			endcase
			send_byte(s[7:0]);
			send_byte(s[15:8]);
		end
	endtask

	task automatic send_packet(input logic [7:0] code, input fill_t fill);
		send_header(code);
		send_samples(ppmas_pkg::POINTS, fill);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (packet_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mask(input logic [ppmas_pkg::CFG_IDX_W-1:0] idx,
			input logic [ppmas_pkg::MASK_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx < ppmas_pkg::AREAS)
			area_masks[idx[1:0]] = val;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic randomize_masks();
		logic [ppmas_pkg::MASK_W-1:0] val;
		for (int i = 0; i < ppmas_pkg::AREAS; i++) begin
			case ($urandom_range(7))
			0: val = '0;
			1: val = '1;
			default: val = ppmas_pkg::MASK_W'($urandom());
			endcase
			write_mask(ppmas_pkg::CFG_IDX_W'(i), val);
		end
		write_mask(ppmas_pkg::CFG_IDX_W'($urandom_range(ppmas_pkg::AREAS, 7)),
			ppmas_pkg::MASK_W'($urandom()));
	endtask

	task automatic test_area_codes();
		for (int k = 0; k < ppmas_pkg::AREAS; k++)
			send_packet(ppmas_pkg::AREA_FIRST + 8'(k), FILL_RANDOM);
		wait_idle();
	endtask

	task automatic test_extreme_samples();
		send_packet(ppmas_pkg::AREA_FIRST + 8'd1, FILL_MAX);
		send_packet(ppmas_pkg::AREA_FIRST + 8'd2, FILL_ZERO);
		wait_idle();
	endtask

	task automatic test_unknown_area();
		send_packet(ppmas_pkg::AREA_FIRST - 8'd1, FILL_MAX);
		send_packet(ppmas_pkg::AREA_LAST + 8'd1, FILL_MAX);
		send_packet(ppmas_pkg::HDR_B0, FILL_MAX);
		send_packet(ppmas_pkg::AREA_FIRST + 8'd1, FILL_RANDOM);
		wait_idle();
	endtask

	task automatic test_broken_header();
		send_byte(ppmas_pkg::HDR_B0);
		send_byte(ppmas_pkg::HDR_B1);
		send_packet(ppmas_pkg::AREA_FIRST + 8'd1, FILL_RANDOM);
		send_byte(ppmas_pkg::HDR_B0);
		send_packet(ppmas_pkg::AREA_FIRST + 8'd2, FILL_RANDOM);
		send_byte(ppmas_pkg::HDR_B0);
		send_byte(ppmas_pkg::HDR_B1);
		send_byte(ppmas_pkg::HDR_B1);
		send_packet(ppmas_pkg::AREA_LAST, FILL_MIXED);
		wait_idle();
	endtask

	task automatic test_mask_mid_packet();
		send_header(ppmas_pkg::AREA_FIRST);
		send_samples(10, FILL_MAX);
		wait_idle();
		write_mask(ppmas_pkg::REG_TOE, 28'h0AAAAAAA);
		send_samples(ppmas_pkg::POINTS - 10, FILL_MAX);
		send_header(ppmas_pkg::AREA_LAST);
		send_samples(20, FILL_MIXED);
		wait_idle();
		write_mask(ppmas_pkg::REG_HEEL, 28'h0555AAAA);
		send_samples(ppmas_pkg::POINTS - 20, FILL_MAX);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		for (int i = 0; i < ppmas_pkg::AREAS; i++)
			write_mask(ppmas_pkg::CFG_IDX_W'(i), '0);
		send_packet(ppmas_pkg::AREA_FIRST + 8'($urandom_range(3)), FILL_MAX);
		wait_idle();
		for (int i = 0; i < ppmas_pkg::AREAS; i++)
			write_mask(ppmas_pkg::CFG_IDX_W'(i), '1);
		send_packet(ppmas_pkg::AREA_LAST, FILL_MAX);
		wait_idle();
		for (int i = ppmas_pkg::AREAS; i < 8; i++)
			write_mask(ppmas_pkg::CFG_IDX_W'(i), '0);
		send_packet(ppmas_pkg::AREA_FIRST + 8'($urandom_range(3)), FILL_MIXED);
		wait_idle();
	endtask

	task automatic test_backpressure();
		int saved_pct;
		saved_pct = send_idle_pct;
		send_idle_pct = 0;
		hold_len = HOLD_CYCLES;
		repeat (3)
			send_packet(ppmas_pkg::AREA_FIRST + 8'($urandom_range(3)), FILL_RANDOM);
		wait_idle();
		send_idle_pct = saved_pct;
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		int start_bytes;
		int known;
		int r;
		logic [7:0] code;
		logic paused;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start_bytes = bytes_sent;
		known = 0;
		paused = 1'b0;
		while (bytes_sent - start_bytes < 100 || known < 2) begin
			r = $urandom_range(99);
			if (r < 78) begin
				repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
				if ($urandom_range(9) == 0)
					code = 8'($urandom_range(255));
				else
					code = ppmas_pkg::AREA_FIRST + 8'($urandom_range(3));
				if (code >= ppmas_pkg::AREA_FIRST && code <= ppmas_pkg::AREA_LAST)
					known++;
				send_header(code);
				send_samples(ppmas_pkg::POINTS, fill_t'($urandom_range(3)));
			end else if (r < 90) begin
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
			end else begin
				send_byte(ppmas_pkg::HDR_B0);
				if ($urandom_range(1))
					send_byte(ppmas_pkg::HDR_B1);
				send_byte($urandom_range(1) ? ppmas_pkg::HDR_B0 : 8'($urandom_range(255)));
			end
			if (!paused && bytes_sent - start_bytes >= 50) begin
				paused = 1'b1;
				wait_idle();
			end
		end
		wait_idle();
	endtask

	initial begin
		area_masks[0] = ppmas_pkg::TOE_RST;
		area_masks[1] = ppmas_pkg::FOREFOOT_RST;
		area_masks[2] = ppmas_pkg::MIDFOOT_RST;
		area_masks[3] = ppmas_pkg::HEEL_RST;
		parse_phase = ppmas_pkg::PH_HUNT;
		cur_area = '0;
		cur_known = 1'b0;
		low_hold = '0;
		samp_idx = '0;
		run_sum = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_area_codes();
		test_extreme_samples();
		test_unknown_area();
		test_broken_header();
		test_mask_mid_packet();
		test_register_extremes();
		test_backpressure();
		randomize_masks();
		test_random_traffic(23, 62);
		randomize_masks();
		test_random_traffic(62, 23);
		randomize_masks();
		test_random_traffic(0, 0);

		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### pressure_packet_masked_area_summer.f
rtl/ppmas_pkg.sv
rtl/ppmas_cfg.sv
rtl/ppmas_parse.sv
rtl/ppmas_outq.sv
rtl/pressure_packet_masked_area_summer.sv
rtl/ppmas_chk.sv
tb/tb_pressure_packet_masked_area_summer.sv
